[rtl/lff_pkg.sv]
package lff_pkg;

  // Q16.16 one as a Q32.32 value
  localparam logic signed [64:0] OneQ32 = 65'sh1_0000_0000;

  // reset value of both dimensions: 1.0
  localparam logic [30:0] DefaultDim = 31'd65536;

  localparam int CfgIdxW = 2;

  // quotient bits produced by the divider, one per stage
  localparam int DivBits = 33;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeight = 2'd0,
    CfgWidth  = 2'd1
  } cfg_idx_e;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic       fault;
    logic [5:0] k;
    logic       neg_re;
    logic       neg_im;
  } div_side_t;

endpackage

[rtl/lff_if.sv]
interface lff_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] qx_re;
  logic signed [31:0] qx_im;
  logic signed [31:0] qy_re;
  logic signed [31:0] qy_im;
  logic signed [31:0] qz_re;
  logic signed [31:0] qz_im;

  modport source (output valid, qx_re, qx_im, qy_re, qy_im, qz_re, qz_im, input ready);
  modport sink   (input valid, qx_re, qx_im, qy_re, qy_im, qz_re, qz_im, output ready);
endinterface

interface lff_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ff_re;
  logic signed [31:0] ff_im;
  logic               range_fault;

  modport source (output valid, ff_re, ff_im, range_fault, input ready);
  modport sink   (input valid, ff_re, ff_im, range_fault, output ready);
endinterface

[rtl/lff_div.sv]
module lff_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [60:0]         n_i,
  input  logic [60:0]         r_re_i,
  input  logic [32:0]         lo_re_i,
  input  logic [60:0]         r_im_i,
  input  logic [32:0]         lo_im_i,
  input  lff_pkg::div_side_t  side_i,
  output logic                valid_o,
  output logic [32:0]         t_re_o,
  output logic [32:0]         t_im_o,
  output lff_pkg::div_side_t  side_o
);

  localparam int Steps = lff_pkg::DivBits;

  logic [Steps-1:0]   v_q;
  logic [60:0]        n_q    [Steps];
  logic [60:0]        r_re_q [Steps];
  logic [60:0]        r_im_q [Steps];
  logic [32:0]        lo_re_q[Steps];
  logic [32:0]        lo_im_q[Steps];
  logic [32:0]        t_re_q [Steps];
  logic [32:0]        t_im_q [Steps];
  lff_pkg::div_side_t side_q [Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [60:0]        n_s, r_re_s, r_im_s;
    logic [32:0]        lo_re_s, lo_im_s, t_re_s, t_im_s;
    lff_pkg::div_side_t side_s;
    logic [61:0]        rr2, ri2;
    logic               ge_re, ge_im;

    if (j == 0) begin : g_head
      assign n_s     = n_i;
      assign r_re_s  = r_re_i;
      assign r_im_s  = r_im_i;
      assign lo_re_s = lo_re_i;
      assign lo_im_s = lo_im_i;
      assign t_re_s  = '0;
      assign t_im_s  = '0;
      assign side_s  = side_i;
    end else begin : g_body
      assign n_s     = n_q[j-1];
      assign r_re_s  = r_re_q[j-1];
      assign r_im_s  = r_im_q[j-1];
      assign lo_re_s = lo_re_q[j-1];
      assign lo_im_s = lo_im_q[j-1];
      assign t_re_s  = t_re_q[j-1];
      assign t_im_s  = t_im_q[j-1];
      assign side_s  = side_q[j-1];
    end

    // shift in the next numerator bit, subtract if it fits
    assign rr2   = {r_re_s, lo_re_s[32]};
    assign ri2   = {r_im_s, lo_im_s[32]};
    assign ge_re = rr2 >= {1'b0, n_s};
    assign ge_im = ri2 >= {1'b0, n_s};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j]     <= n_s;
        r_re_q[j]  <= ge_re ? 61'(rr2 - {1'b0, n_s}) : rr2[60:0];
        r_im_q[j]  <= ge_im ? 61'(ri2 - {1'b0, n_s}) : ri2[60:0];
        lo_re_q[j] <= {lo_re_s[31:0], 1'b0};
        lo_im_q[j] <= {lo_im_s[31:0], 1'b0};
        t_re_q[j]  <= {t_re_s[31:0], ge_re};
        t_im_q[j]  <= {t_im_s[31:0], ge_im};
        side_q[j]  <= side_s;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign t_re_o  = t_re_q[Steps-1];
  assign t_im_o  = t_im_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

[rtl/lff_factor.sv]
module lff_factor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [30:0]        s_i,
  input  logic signed [31:0] q_re_i,
  input  logic signed [31:0] q_im_i,
  output logic               valid_o,
  output logic               fault_o,
  output logic signed [31:0] g_re_o,
  output logic signed [31:0] g_im_o
);

  logic [8:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[7:0], valid_i};
    end
  end

  // stage 1: s*q
  logic signed [63:0] p_re_q, p_im_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_re_q <= $signed({1'b0, s_i}) * q_re_i;
      p_im_q <= $signed({1'b0, s_i}) * q_im_i;
    end
  end

  // stage 2: a = round(s*q / 2^17), range check
  logic [62:0]        pm_re, pm_im;
  logic [45:0]        am_re, am_im;
  logic signed [31:0] a_re_q, a_im_q;
  logic               f2_q;
  assign pm_re = p_re_q[63] ? 63'(-p_re_q) : p_re_q[62:0];
  assign pm_im = p_im_q[63] ? 63'(-p_im_q) : p_im_q[62:0];
  assign am_re = 46'((pm_re + 63'd65536) >> 17);
  assign am_im = 46'((pm_im + 63'd65536) >> 17);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_re_q <= p_re_q[63] ? -$signed({1'b0, am_re[30:0]}) : $signed({1'b0, am_re[30:0]});
      a_im_q <= p_im_q[63] ? -$signed({1'b0, am_im[30:0]}) : $signed({1'b0, am_im[30:0]});
      f2_q   <= (|am_re[45:31]) || (|am_im[45:31]);
    end
  end

  // stage 3: squares and cross product
  logic signed [63:0] sq_re_q, sq_im_q, cr_q;
  logic               f3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_re_q <= a_re_q * a_re_q;
      sq_im_q <= a_im_q * a_im_q;
      cr_q    <= a_re_q * a_im_q;
      f3_q    <= f2_q;
    end
  end

  // stage 4: d = 1 + a^2, split into sign and magnitude
  logic signed [64:0] dr, di;
  logic [62:0]        mr_q, mi_q;
  logic               nr_neg_q, ni_neg_q, f4_q;
  assign dr = 65'(sq_re_q) - 65'(sq_im_q) + lff_pkg::OneQ32;
  assign di = 65'(cr_q) <<< 1;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mr_q     <= dr[64] ? 63'(-dr) : dr[62:0];
      mi_q     <= di[64] ? 63'(-di) : di[62:0];
      nr_neg_q <= dr[64];
      ni_neg_q <= di[64];
      f4_q     <= f3_q;
    end
  end

  // stage 5: leading-one search, first level over bytes
  logic [63:0]      m_all;
  logic [7:0]       grp_nz;
  logic [2:0]       grp_msb  [8];
  logic [7:0]       grp_nz_q;
  logic [2:0]       grp_msb_q[8];
  logic [62:0]      mr5_q, mi5_q;
  logic             nr5_q, ni5_q, f5_q;
  assign m_all = {1'b0, mr_q | mi_q};
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_nz[g]  = |m_all[8*g +: 8];
      grp_msb[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (m_all[8*g+b]) begin
          grp_msb[g] = 3'(b);
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_nz_q  <= grp_nz;
      grp_msb_q <= grp_msb;
      mr5_q     <= mr_q;
      mi5_q     <= mi_q;
      nr5_q     <= nr_neg_q;
      ni5_q     <= ni_neg_q;
      f5_q      <= f4_q;
    end
  end

  // stage 6: pick top byte, derive shift k
  logic [2:0]  top;
  logic [5:0]  msb;
  logic [5:0]  k6_q;
  logic [62:0] mr6_q, mi6_q;
  logic        nr6_q, ni6_q, f6_q;
  always_comb begin
    top = '0;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz_q[g]) begin
        top = 3'(g);
      end
    end
    msb = {top, grp_msb_q[top]};
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k6_q  <= (msb >= 6'd30) ? msb - 6'd29 : 6'd0;
      mr6_q <= mr5_q;
      mi6_q <= mi5_q;
      nr6_q <= nr5_q;
      ni6_q <= ni5_q;
      f6_q  <= f5_q;
    end
  end

  // stage 7: normalize
  logic [29:0] nr7_q, ni7_q;
  logic [5:0]  k7_q;
  logic        nr7n_q, ni7n_q, f7_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nr7_q  <= 30'(mr6_q >> k6_q);
      ni7_q  <= 30'(mi6_q >> k6_q);
      k7_q   <= k6_q;
      nr7n_q <= nr6_q;
      ni7n_q <= ni6_q;
      f7_q   <= f6_q;
    end
  end

  // stage 8: |D|^2 terms and numerators s*D
  logic [59:0] nsq_re_q, nsq_im_q;
  logic [60:0] x_re_q, x_im_q;
  logic [5:0]  k8_q;
  logic        nr8_q, ni8_q, f8_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nsq_re_q <= nr7_q * nr7_q;
      nsq_im_q <= ni7_q * ni7_q;
      x_re_q   <= s_i * nr7_q;
      x_im_q   <= s_i * ni7_q;
      k8_q     <= k7_q;
      nr8_q    <= nr7n_q;
      ni8_q    <= ni7n_q;
      f8_q     <= f7_q;
    end
  end

  // stage 9: divisor, overflow precheck, divider seed
  logic [60:0]        n9, xs_re, xs_im;
  logic [60:0]        n9_q, r_re_q, r_im_q;
  logic [32:0]        lo_re_q, lo_im_q;
  lff_pkg::div_side_t side9_q;
  assign n9    = 61'(nsq_re_q) + 61'(nsq_im_q);
  assign xs_re = x_re_q >> k8_q;
  assign xs_im = x_im_q >> k8_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n9_q           <= n9;
      r_re_q         <= xs_re;
      r_im_q         <= xs_im;
      lo_re_q        <= 33'({x_re_q, 33'd0} >> k8_q);
      lo_im_q        <= 33'({x_im_q, 33'd0} >> k8_q);
      side9_q.fault  <= f8_q || (n9 == '0) || (xs_re >= n9) || (xs_im >= n9);
      side9_q.k      <= k8_q;
      side9_q.neg_re <= nr8_q;
      side9_q.neg_im <= ni8_q;
    end
  end

  logic               dv;
  logic [32:0]        t_re, t_im;
  lff_pkg::div_side_t dside;

  lff_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q[8]),
    .n_i     (n9_q),
    .r_re_i  (r_re_q),
    .lo_re_i (lo_re_q),
    .r_im_i  (r_im_q),
    .lo_im_i (lo_im_q),
    .side_i  (side9_q),
    .valid_o (dv),
    .t_re_o  (t_re),
    .t_im_o  (t_im),
    .side_o  (dside)
  );

  // final: round by one bit, limit check, apply conjugate signs
  logic [32:0]        lim;
  logic [31:0]        vr, vi;
  logic               vf_q, ff_q;
  logic signed [31:0] g_re_q, g_im_q;
  always_comb begin
    case (dside.k)
      6'd31:   lim = 33'h0_8000_0000;
      6'd32:   lim = 33'h0_4000_0000;
      6'd33:   lim = 33'h0_2000_0000;
      default: lim = 33'h0_FFFF_FFFF;
    endcase
  end
  assign vr = 32'((34'(t_re) + 34'd1) >> 1);
  assign vi = 32'((34'(t_im) + 34'd1) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ff_q   <= dside.fault || (t_re >= lim) || (t_im >= lim);
      g_re_q <= dside.neg_re ? -$signed(vr) : $signed(vr);
      g_im_q <= dside.neg_im ? $signed(vi) : -$signed(vi);
    end
  end

  assign valid_o = vf_q;
  assign fault_o = ff_q;
  assign g_re_o  = g_re_q;
  assign g_im_o  = g_im_q;

endmodule

[rtl/lff_cmul.sv]
module lff_cmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               fault_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               valid_o,
  output logic               fault_o,
  output logic signed [31:0] p_re_o,
  output logic signed [31:0] p_im_o
);

  logic [1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  // stage 1: partial products
  logic signed [63:0] m1_q, m2_q, m3_q, m4_q;
  logic               f1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= a_re_i * b_re_i;
      m2_q <= a_im_i * b_im_i;
      m3_q <= a_re_i * b_im_i;
      m4_q <= a_im_i * b_re_i;
      f1_q <= fault_i;
    end
  end

  // stage 2: sum, round to Q16.16, range check
  logic signed [64:0] re, im;
  logic [63:0]        mg_re, mg_im;
  logic [48:0]        rm_re, rm_im;
  logic               f2_q;
  logic signed [31:0] p_re_q, p_im_q;
  assign re    = 65'(m1_q) - 65'(m2_q);
  assign im    = 65'(m3_q) + 65'(m4_q);
  assign mg_re = re[64] ? 64'(-re) : re[63:0];
  assign mg_im = im[64] ? 64'(-im) : im[63:0];
  assign rm_re = 49'((65'(mg_re) + 65'd32768) >> 16);
  assign rm_im = 49'((65'(mg_im) + 65'd32768) >> 16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f2_q   <= f1_q || (|rm_re[48:31]) || (|rm_im[48:31]);
      p_re_q <= re[64] ? -$signed({1'b0, rm_re[30:0]}) : $signed({1'b0, rm_re[30:0]});
      p_im_q <= im[64] ? -$signed({1'b0, rm_im[30:0]}) : $signed({1'b0, rm_im[30:0]});
    end
  end

  assign valid_o = v_q[1];
  assign fault_o = f2_q;
  assign p_re_o  = p_re_q;
  assign p_im_o  = p_im_q;

endmodule

[rtl/lorentz_form_factor.sv]
// Lorentzian form factor unit. Each beat on q_chan carries one complex
// scattering vector (qx, qy, qz; signed Q16.16 real and imaginary parts) and
// yields exactly one beat on ff_chan with the complex form factor
// W*W*H / ((1+(W*qx/2)^2)(1+(W*qy/2)^2)(1+(H*qz/2)^2)) in signed Q16.16.
// H (index 0) and W (index 1) are unsigned Q16.16, reset to 1.0; the user
// must write them through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the
// unit is empty; the unit does not enforce this. range_fault flags a zero
// denominator or any intermediate that leaves the Q16.16 range; the result
// is then zero. Each beat passes through three factor lanes of 43 stages
// each (9 arithmetic and normalization stages, a 33-stage restoring
// divider producing one quotient bit per stage, and a final rounding
// stage), two 2-stage complex multipliers, and the output register. The
// unit takes one beat per cycle unless the output register holds a beat
// that is not taken; then the whole pipeline holds and q_chan.ready drops.
module lorentz_form_factor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lff_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [30:0]                  cfg_wdata_i,
  lff_in_if.sink                       q_chan,
  lff_out_if.source                    ff_chan
);

  // configuration registers
  logic [30:0] height_q, width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= lff_pkg::DefaultDim;
      width_q  <= lff_pkg::DefaultDim;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lff_pkg::CfgHeight: height_q <= cfg_wdata_i;
        lff_pkg::CfgWidth:  width_q  <= cfg_wdata_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // advance the whole pipeline unless the output beat is stuck
  logic out_valid_q;
  logic en;
  assign en           = !out_valid_q || ff_chan.ready;
  assign q_chan.ready = en;

  // one factor lane per axis
  logic               vx, vy, vz, fx, fy, fz;
  logic signed [31:0] gx_re, gx_im, gy_re, gy_im, gz_re, gz_im;

  lff_factor u_fx (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (q_chan.valid),
    .s_i (width_q), .q_re_i (q_chan.qx_re), .q_im_i (q_chan.qx_im),
    .valid_o (vx), .fault_o (fx), .g_re_o (gx_re), .g_im_o (gx_im)
  );

  lff_factor u_fy (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (q_chan.valid),
    .s_i (width_q), .q_re_i (q_chan.qy_re), .q_im_i (q_chan.qy_im),
    .valid_o (vy), .fault_o (fy), .g_re_o (gy_re), .g_im_o (gy_im)
  );

  lff_factor u_fz (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (q_chan.valid),
    .s_i (height_q), .q_re_i (q_chan.qz_re), .q_im_i (q_chan.qz_im),
    .valid_o (vz), .fault_o (fz), .g_re_o (gz_re), .g_im_o (gz_im)
  );

  // gx * gy
  logic               vp, fp;
  logic signed [31:0] p_re, p_im;

  lff_cmul u_cm_xy (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .valid_i (vx), .fault_i (fx || fy),
    .a_re_i (gx_re), .a_im_i (gx_im), .b_re_i (gy_re), .b_im_i (gy_im),
    .valid_o (vp), .fault_o (fp), .p_re_o (p_re), .p_im_o (p_im)
  );

  // hold gz for the two stages of the first multiplier
  logic signed [31:0] z1_re_q, z1_im_q, z2_re_q, z2_im_q;
  logic               z1_f_q, z2_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z1_re_q <= gz_re;
      z1_im_q <= gz_im;
      z1_f_q  <= fz;
      z2_re_q <= z1_re_q;
      z2_im_q <= z1_im_q;
      z2_f_q  <= z1_f_q;
    end
  end

  // (gx*gy) * gz
  logic               vf, ff;
  logic signed [31:0] f_re, f_im;

  lff_cmul u_cm_pz (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .valid_i (vp), .fault_i (fp || z2_f_q),
    .a_re_i (p_re), .a_im_i (p_im), .b_re_i (z2_re_q), .b_im_i (z2_im_q),
    .valid_o (vf), .fault_o (ff), .p_re_o (f_re), .p_im_o (f_im)
  );

  // output register: force zero on fault
  logic signed [31:0] ff_re_q, ff_im_q;
  logic               fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ff_re_q <= ff ? '0 : f_re;
      ff_im_q <= ff ? '0 : f_im;
      fault_q <= ff;
    end
  end

  assign ff_chan.valid       = out_valid_q;
  assign ff_chan.ff_re       = ff_re_q;
  assign ff_chan.ff_im       = ff_im_q;
  assign ff_chan.range_fault = fault_q;

  // the three lanes must stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vx == vy) && (vx == vz))
    else $error("factor lanes out of step");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ff_chan.valid && ff_chan.range_fault |-> (ff_chan.ff_re == 0) && (ff_chan.ff_im == 0))
    else $error("faulted beat carries nonzero result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ff_chan.valid |-> q_chan.ready)
    else $error("input stalled with empty output register");

  a_cfg_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == lff_pkg::CfgWidth) |=> width_q == $past(cfg_wdata_i))
    else $error("width write lost");

endmodule

[tb/lorentz_form_factor_tb.sv]
`timescale 1ns / 100ps

module lorentz_form_factor_tb;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [lff_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam longint unsigned MagMax = 64'h7FFF_FFFF;
  localparam int CycleLimit = 400000;
  // Extra wait after the last result, with slack past the pipeline depth.
  localparam int DrainCycles = 64;
  localparam int RandomItems = 750;

  typedef struct {
    logic signed [31:0] qx_re, qx_im, qy_re, qy_im, qz_re, qz_im;
  } q_vec_t;

  typedef struct {
    logic signed [31:0] ff_re, ff_im;
    logic               fault;
  } ff_res_t;

  // Predicts the form factor of each accepted q vector and holds the
  // predictions until the matching result beat arrives.
  class ff_scoreboard;
    longint  dim_h = 65536;
    longint  dim_w = 65536;
    ff_res_t pending[$];
    int      errors = 0;
    int      checked = 0;
    int      faults = 0;

    function void set_dim(logic [lff_pkg::CfgIdxW-1:0] idx, logic [30:0] val);
      if (idx == lff_pkg::CfgHeight) dim_h = longint'({33'd0, val});
      else if (idx == lff_pkg::CfgWidth) dim_w = longint'({33'd0, val});
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // round to nearest, ties away from zero
    function longint round_shift(longint v, int n);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (n - 1))) >> n;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // magnitude of round(x * 2^(32-k) / n), long division one bit per step
    function bit scaled_div(longint unsigned x, longint unsigned n, int k,
                            output longint unsigned res);
      longint unsigned lim, quo, rem;
      lim = (k <= 30) ? (64'd1 << (32 + k)) : (64'd1 << 62);
      quo = x / n;
      rem = x % n;
      for (int i = 0; i < 33; i++) begin
        if (quo >= lim) return 0;
        quo = quo << 1;
        rem = rem << 1;
        if (rem >= n) begin
          rem = rem - n;
          quo = quo | 64'd1;
        end
      end
      if (quo >= lim) return 0;
      quo = (quo + (64'd1 << k)) >> (k + 1);
      if (quo > MagMax) return 0;
      res = quo;
      return 1;
    endfunction

    // g = s / (1 + (s*q/2)^2)
    function bit lorentz_factor(longint s, longint qr, longint qi,
                                output longint gr, output longint gi);
      longint ar, ai, dr, di;
      longint unsigned mr, mi, nr, ni, n, vr, vi;
      int k;
      ar = round_shift(s * qr, 17);
      ai = round_shift(s * qi, 17);
      k = 0;
      if (mag(ar) > MagMax || mag(ai) > MagMax) return 0;
      dr = ar * ar - ai * ai + 64'sh1_0000_0000;
      di = 2 * (ar * ai);
      mr = mag(dr);
      mi = mag(di);
      while ((mr >> k) >= (64'd1 << 30) || (mi >> k) >= (64'd1 << 30)) k++;
      nr = mr >> k;
      ni = mi >> k;
      n = nr * nr + ni * ni;
      if (n == 0) return 0;
      if (!scaled_div(longint'(s) * nr, n, k, vr)) return 0;
      if (!scaled_div(longint'(s) * ni, n, k, vi)) return 0;
      gr = dr < 0 ? -longint'(vr) : longint'(vr);
      gi = di < 0 ? longint'(vi) : -longint'(vi);
      return 1;
    endfunction

    function bit cplx_mul(longint ar, longint ai, longint br, longint bi,
                          output longint rr, output longint ri);
      longint re, im;
      re = round_shift(ar * br - ai * bi, 16);
      im = round_shift(ar * bi + ai * br, 16);
      if (mag(re) > MagMax || mag(im) > MagMax) return 0;
      rr = re;
      ri = im;
      return 1;
    endfunction

    function void note_q(q_vec_t q);
      longint xr, xi, yr, yi, zr, zi, pr, pi, fr, fi;
      ff_res_t e;
      bit ok;
      ok = lorentz_factor(dim_w, q.qx_re, q.qx_im, xr, xi)
        && lorentz_factor(dim_w, q.qy_re, q.qy_im, yr, yi)
        && lorentz_factor(dim_h, q.qz_re, q.qz_im, zr, zi)
        && cplx_mul(xr, xi, yr, yi, pr, pi)
        && cplx_mul(pr, pi, zr, zi, fr, fi);
      if (ok) begin
        e.ff_re = fr[31:0];
        e.ff_im = fi[31:0];
        e.fault = 1'b0;
      end else begin
        e.ff_re = '0;
        e.ff_im = '0;
        e.fault = 1'b1;
      end
      pending.push_back(e);
    endfunction

    function void check_ff(ff_res_t got);
      ff_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h fault=%b", $time,
                 got.ff_re, got.ff_im, got.fault);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.fault) faults++;
      if (got.ff_re !== e.ff_re) begin
        $display("%0t: ff_re expected %h got %h", $time, e.ff_re, got.ff_re);
        errors++;
      end
      if (got.ff_im !== e.ff_im) begin
        $display("%0t: ff_im expected %h got %h", $time, e.ff_im, got.ff_im);
        errors++;
      end
      if (got.fault !== e.fault) begin
        $display("%0t: range_fault expected %b got %b", $time, e.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [lff_pkg::CfgIdxW-1:0]  cfg_idx_i = lff_pkg::CfgHeight;
  logic [30:0]                  cfg_wdata_i = '0;

  lff_in_if  q_chan ();
  lff_out_if ff_chan ();

  ff_scoreboard sb = new();
  int  cycle = 0;
  int  sent = 0;
  bit  held_off = 0;

  lorentz_form_factor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_chan      (q_chan),
    .ff_chan     (ff_chan)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle,
               sb.pending.size());
      $display("lorentz_form_factor test failed");
      $finish;
    end
  end

  // Mostly no gap, some short ones and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: stall at random, with stall-free stretches, and hold off once
  // for a long stretch so the pipeline fills up and drops q_chan.ready.
  initial begin
    int stall;
    ff_res_t got;
    ff_chan.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && sb.checked >= 300) begin
        held_off = 1;
        ff_chan.ready = 1'b0;
        repeat (200) @(negedge clk_i);
      end
      stall = ((cycle >> 9) % 4 == 0) ? 0 : pick_gap();
      if (stall > 0) begin
        ff_chan.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      ff_chan.ready = 1'b1;
      // Take one beat, then fall through to pick the next stall.
      do begin
        @(posedge clk_i);
      end while (!ff_chan.valid);
      got.ff_re = ff_chan.ff_re;
      got.ff_im = ff_chan.ff_im;
      got.fault = ff_chan.range_fault;
      sb.check_ff(got);
    end
  end

  // Drive one beat starting at a falling edge; return at the falling edge
  // after acceptance with valid still high, so back-to-back beats need no
  // lower-and-raise.
  task automatic send_q(q_vec_t q, bit allow_gap);
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      q_chan.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    q_chan.qx_re = q.qx_re;
    q_chan.qx_im = q.qx_im;
    q_chan.qy_re = q.qy_re;
    q_chan.qy_im = q.qy_im;
    q_chan.qz_re = q.qz_re;
    q_chan.qz_im = q.qz_im;
    q_chan.valid = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!q_chan.ready);
    sb.note_q(q);
    sent++;
    @(negedge clk_i);
  endtask

  // Drain, wait out the pipeline, then write a register.
  task automatic write_dim(logic [lff_pkg::CfgIdxW-1:0] idx, logic [30:0] val);
    q_chan.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_dim(idx, val);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 524288)) - 262144;
      5:             return $urandom();
      6:             return 32'sd0;
      7:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8:             return $signed(1 << $urandom_range(0, 30))
                            * ($urandom_range(0, 1) ? 1 : -1);
      default:       return ($urandom_range(0, 1) ? 131072 : -131072)
                            + $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic q_vec_t rand_q();
    q_vec_t q;
    q.qx_re = rand_comp();
    q.qy_re = rand_comp();
    q.qz_re = rand_comp();
    // Real-q variant: imaginary parts all zero for about a fifth of beats.
    if ($urandom_range(0, 4) == 0) begin
      q.qx_im = 0;
      q.qy_im = 0;
      q.qz_im = 0;
    end else begin
      q.qx_im = rand_comp();
      q.qy_im = rand_comp();
      q.qz_im = rand_comp();
    end
    return q;
  endfunction

  function automatic q_vec_t mk_q(logic signed [31:0] a, b, c, d, e, f);
    q_vec_t q;
    q.qx_re = a; q.qx_im = b; q.qy_re = c; q.qy_im = d; q.qz_re = e; q.qz_im = f;
    return q;
  endfunction

  // Directed beats: zero q, small values, the exact zero denominator
  // (a = +-i), overflowing q and the extreme field values.
  task automatic run_directed();
    send_q(mk_q(0, 0, 0, 0, 0, 0), 0);
    send_q(mk_q(65536, 0, -65536, 0, 32768, 0), 0);
    send_q(mk_q(0, 131072, 0, 0, 0, 0), 0);
    send_q(mk_q(0, 0, 0, -131072, 0, 0), 0);
    send_q(mk_q(0, 0, 0, 0, 0, 131072), 0);
    send_q(mk_q(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 0);
    send_q(mk_q(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 0);
    send_q(mk_q(1, -1, 1, -1, 1, -1), 1);
    send_q(mk_q(20000, -70000, 45000, 12345, -99999, 3), 1);
  endtask

  initial begin
    int seg_items;
    q_chan.valid = 1'b0;
    q_chan.qx_re = '0; q_chan.qx_im = '0;
    q_chan.qy_re = '0; q_chan.qy_im = '0;
    q_chan.qz_re = '0; q_chan.qz_im = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset dimensions (1.0 x 1.0).
    run_directed();

    // Unused index must leave both dimensions alone.
    write_dim(CfgUnused, 31'd12345);
    write_dim(lff_pkg::CfgHeight, 31'd32768);
    write_dim(lff_pkg::CfgWidth, 31'd131072);
    run_directed();

    // Extremes: largest width with zero height, then the reverse.
    write_dim(lff_pkg::CfgWidth, 31'h7FFF_FFFF);
    write_dim(lff_pkg::CfgHeight, 31'd0);
    run_directed();
    write_dim(lff_pkg::CfgWidth, 31'd0);
    write_dim(lff_pkg::CfgHeight, 31'h7FFF_FFFF);
    run_directed();

    // Random beats across several dimension settings; the last restores 1.0.
    for (int seg = 0; seg < 5; seg++) begin
      if (seg == 4) begin
        write_dim(lff_pkg::CfgHeight, 31'd65536);
        write_dim(lff_pkg::CfgWidth, 31'd65536);
      end else begin
        write_dim(lff_pkg::CfgHeight, $urandom_range(0, 3) == 0 ?
                  31'($urandom()) : 31'($urandom_range(1, 262144)));
        write_dim(lff_pkg::CfgWidth, $urandom_range(0, 3) == 0 ?
                  31'($urandom()) : 31'($urandom_range(1, 262144)));
      end
      seg_items = RandomItems / 5;
      for (int i = 0; i < seg_items; i++)
        send_q(rand_q(), (i / 40) % 3 != 0);
    end
    q_chan.valid = 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("sent %0d q vectors over 9 dimension settings, checked %0d results",
             sent, sb.checked);
    $display("%0d results flagged range_fault, long receiver hold-off %0s",
             sb.faults, held_off ? "done" : "not reached");
    if (sb.errors == 0) begin
      $display("lorentz_form_factor test passed");
    end else begin
      $display("lorentz_form_factor test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lff_pkg.sv
rtl/lff_if.sv
rtl/lff_div.sv
rtl/lff_factor.sv
rtl/lff_cmul.sv
rtl/lorentz_form_factor.sv
tb/lorentz_form_factor_tb.sv
